@@ rtl/counting_semaphore_table_core_macros.svh @@
// assertion macros shared by the semaphore table rtl
`ifndef COUNTING_SEMAPHORE_TABLE_CORE_MACROS_SVH
`define COUNTING_SEMAPHORE_TABLE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// clocked check, disabled while reset is high
`define CSEM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds during reset
`define CSEM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSEM_ASSERT(lbl, clk, rst, prop, msg)
`define CSEM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/csem_pkg.sv @@
// shared codes, widths and types of the semaphore table
`timescale 1ns / 1ps
package csem_pkg;
   localparam int PID_W = 4;
   localparam int CNT_W = 16;
   localparam int STATUS_W = 3;

   localparam logic [1:0] REQ_OPEN  = 2'd0;
   localparam logic [1:0] REQ_WAIT  = 2'd1;
   localparam logic [1:0] REQ_POST  = 2'd2;
   localparam logic [1:0] REQ_CLOSE = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NOMEM   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_INVALID = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_BLOCKED = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_WOKEN   = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_CLOSED  = 3'd5;

   typedef struct packed {
      logic signed [CNT_W-1:0] cnt;
      logic                    neg;
      logic                    le_zero;
   } alu_res_type;
endpackage

@@ rtl/counting_semaphore_table_core.sv @@
// semaphore table top level: slot scan sequencer, slot and waiter memories
//
// channel   direction  handshake
// req_*     in         taken when start is high and busy is low
// rsp_*     out        one cycle per result, marked by rsp_valid
//
// open is busy in the open state only. wait, post and close scan the slot memory one slot at a time
// (read, compare) up to the first matching slot, then pass through an execute state;
// post adds a pop and a done state when it wakes a waiter, close with waiters a drain state per
// waiter plus a done state. busy drops in the cycle in which the final result (rsp_last) shows.
// the receiver cannot stall; reset clears the valid bits and sets next id to one.
`timescale 1ns / 1ps
`include "counting_semaphore_table_core_macros.svh"
module counting_semaphore_table_core
   import csem_pkg::*;
#(
   parameter int NUM_SEMS  = 16,
   parameter int MAX_PROCS = 16,
   parameter int ID_BITS   = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_type,
   input  logic [PID_W-1:0]           req_caller_pid,
   input  logic [ID_BITS-1:0]         req_sem_id,
   input  logic signed [CNT_W-1:0]    req_init_count,
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [ID_BITS-1:0]         rsp_new_id,
   output logic [PID_W-1:0]           rsp_pid,
   output logic                       rsp_last
);
   localparam int SW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int HW  = $clog2(MAX_PROCS);
   localparam int NW  = $clog2(MAX_PROCS + 1);
   localparam int FD  = NUM_SEMS * MAX_PROCS;
   localparam int FAW = $clog2(FD);
   localparam int RW  = ID_BITS + CNT_W + HW + NW;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_OPEN     = 3'd1;
   localparam logic [2:0] S_SCAN_RD  = 3'd2;
   localparam logic [2:0] S_SCAN_CMP = 3'd3;
   localparam logic [2:0] S_EXEC     = 3'd4;
   localparam logic [2:0] S_POP      = 3'd5;
   localparam logic [2:0] S_DRAIN    = 3'd6;
   localparam logic [2:0] S_DONE     = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic [1:0]              type_ff, type_in;
   logic [PID_W-1:0]        pid_ff, pid_in;
   logic [ID_BITS-1:0]      id_ff, id_in;
   logic signed [CNT_W-1:0] init_ff, init_in;
   logic [SW-1:0]           slot_ff, slot_in;
   logic signed [CNT_W-1:0] cnt_ff, cnt_in;
   logic [HW-1:0]           head_ff, head_in;
   logic [NW-1:0]           num_ff, num_in;
   logic [NUM_SEMS-1:0]     valid_ff, valid_in;
   logic [ID_BITS-1:0]      next_id_ff, next_id_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]      rsp_new_id_ff, rsp_new_id_in;
   logic [PID_W-1:0]        rsp_pid_ff, rsp_pid_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    slot_we;
   logic [SW-1:0]           slot_waddr;
   logic [RW-1:0]           slot_wdata;
   logic [RW-1:0]           slot_rdata;
   logic                    fifo_we;
   logic [FAW-1:0]          fifo_waddr;
   logic [FAW-1:0]          fifo_raddr;
   logic [PID_W-1:0]        fifo_rdata;

   logic [ID_BITS-1:0]      rd_id;
   logic signed [CNT_W-1:0] rd_cnt;
   logic [HW-1:0]           rd_head;
   logic [NW-1:0]           rd_num;

   logic [SW-1:0]           free_slot;
   logic                    table_full;
   logic [HW-1:0]           head_inc;
   logic [NW:0]             tail_sum;
   logic [HW-1:0]           tail;
   logic [FAW-1:0]          fifo_base;
   alu_res_type             alu_res;

   assign {rd_id, rd_cnt, rd_head, rd_num} = slot_rdata;

   csem_ram #(.WIDTH(RW), .DEPTH(NUM_SEMS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_ff),
      .rd_data (slot_rdata)
   );

   csem_ram #(.WIDTH(PID_W), .DEPTH(FD)) u_waiter_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (fifo_waddr),
      .wr_data (pid_ff),
      .rd_addr (fifo_raddr),
      .rd_data (fifo_rdata)
   );

   csem_alu u_alu (
      .cnt (cnt_ff),
      .dec (type_ff == REQ_WAIT),
      .res (alu_res)
   );

   // lowest-numbered free slot
   always_comb begin
      free_slot = '0;
      for (int i = NUM_SEMS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SW'(i);
         end
      end
   end
   assign table_full = &valid_ff;

   assign head_inc  = (head_ff == HW'(MAX_PROCS - 1)) ? '0 : head_ff + HW'(1);
   assign tail_sum  = (NW+1)'(head_ff) + (NW+1)'(num_ff);
   assign tail      = (tail_sum >= (NW+1)'(MAX_PROCS)) ?
                      HW'(tail_sum - (NW+1)'(MAX_PROCS)) : HW'(tail_sum);
   assign fifo_base = FAW'(slot_ff * MAX_PROCS);
   assign fifo_waddr = fifo_base + FAW'(tail);
   assign fifo_raddr = fifo_base + FAW'((state_ff == S_DRAIN) ? head_inc : head_ff);

   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      pid_in        = pid_ff;
      id_in         = id_ff;
      init_in       = init_ff;
      slot_in       = slot_ff;
      cnt_in        = cnt_ff;
      head_in       = head_ff;
      num_in        = num_ff;
      valid_in      = valid_ff;
      next_id_in    = next_id_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_new_id_in = '0;
      rsp_pid_in    = pid_ff;
      rsp_last_in   = 1'b1;
      slot_we       = 1'b0;
      slot_waddr    = slot_ff;
      slot_wdata    = {id_ff, cnt_ff, head_ff, num_ff};
      fifo_we       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               type_in  = req_type;
               pid_in   = req_caller_pid;
               id_in    = req_sem_id;
               init_in  = req_init_count;
               slot_in  = '0;
               state_in = (req_type == REQ_OPEN) ? S_OPEN : S_SCAN_RD;
            end
         end
         S_OPEN: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (table_full) begin
               rsp_status_in = STAT_NOMEM;
            end else begin
               slot_we              = 1'b1;
               slot_waddr           = free_slot;
               slot_wdata           = {next_id_ff, init_ff, HW'(0), NW'(0)};
               valid_in[free_slot]  = 1'b1;
               rsp_new_id_in        = next_id_ff;
               next_id_in = (next_id_ff == {ID_BITS{1'b1}}) ?
                            ID_BITS'(1) : next_id_ff + ID_BITS'(1);
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (valid_ff[slot_ff] && rd_id == id_ff) begin
               id_in    = rd_id;
               cnt_in   = rd_cnt;
               head_in  = rd_head;
               num_in   = rd_num;
               state_in = S_EXEC;
            end else if (slot_ff == SW'(NUM_SEMS - 1)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_INVALID;
               state_in      = S_IDLE;
            end else begin
               slot_in  = slot_ff + SW'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_EXEC: begin
            case (type_ff)
               REQ_WAIT: begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
                  if (alu_res.neg) begin
                     if (num_ff >= NW'(MAX_PROCS)) begin
                        rsp_status_in = STAT_NOMEM;
                     end else begin
                        fifo_we       = 1'b1;
                        slot_we       = 1'b1;
                        slot_wdata    = {id_ff, alu_res.cnt, head_ff, num_ff + NW'(1)};
                        rsp_status_in = STAT_BLOCKED;
                     end
                  end else begin
                     slot_we    = 1'b1;
                     slot_wdata = {id_ff, alu_res.cnt, head_ff, num_ff};
                  end
               end
               REQ_POST: begin
                  slot_we = 1'b1;
                  if (alu_res.le_zero && num_ff != '0) begin
                     slot_wdata = {id_ff, alu_res.cnt, head_inc, num_ff - NW'(1)};
                     head_in    = head_inc;
                     num_in     = num_ff - NW'(1);
                     state_in   = S_POP;
                  end else begin
                     slot_wdata   = {id_ff, alu_res.cnt, head_ff, num_ff};
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               default: begin
                  // close: drain the queue first, then free the slot
                  if (num_ff != '0) begin
                     state_in = S_DRAIN;
                  end else begin
                     valid_in[slot_ff] = 1'b0;
                     rsp_valid_in      = 1'b1;
                     state_in          = S_IDLE;
                  end
               end
            endcase
         end
         S_POP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_WOKEN;
            rsp_pid_in    = fifo_rdata;
            rsp_last_in   = 1'b0;
            state_in      = S_DONE;
         end
         S_DRAIN: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_CLOSED;
            rsp_pid_in    = fifo_rdata;
            rsp_last_in   = 1'b0;
            head_in       = head_inc;
            num_in        = num_ff - NW'(1);
            if (num_ff == NW'(1)) begin
               valid_in[slot_ff] = 1'b0;
               state_in          = S_DONE;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         next_id_ff   <= ID_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff       <= type_in;
      pid_ff        <= pid_in;
      id_ff         <= id_in;
      init_ff       <= init_in;
      slot_ff       <= slot_in;
      cnt_ff        <= cnt_in;
      head_ff       <= head_in;
      num_ff        <= num_in;
      rsp_status_ff <= rsp_status_in;
      rsp_new_id_ff <= rsp_new_id_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_new_id = rsp_new_id_ff;
   assign rsp_pid    = rsp_pid_ff;
   assign rsp_last   = rsp_last_ff;

   `CSEM_ASSERT(a_last_ends_transaction, clock, reset, rsp_valid && rsp_last |-> !busy, "final result while still busy")
   `CSEM_ASSERT(a_mid_is_waiter, clock, reset, rsp_valid && !rsp_last |-> (rsp_status == STAT_WOKEN || rsp_status == STAT_CLOSED), "non-final result is not a waiter")
   `CSEM_ASSERT(a_start_busy, clock, reset, start && !busy |=> busy, "accepted transaction did not raise busy")
   `CSEM_ASSERT(a_queue_bound, clock, reset, slot_we |-> slot_wdata[NW-1:0] <= NW'(MAX_PROCS), "waiter count beyond queue depth")
   `CSEM_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !busy && !rsp_valid, "not idle after reset")
endmodule

@@ rtl/csem_ram.sv @@
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module csem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/csem_alu.sv @@
// shared saturating count unit: increment or decrement and sign tests
`timescale 1ns / 1ps
module csem_alu
   import csem_pkg::*;
(
   input  logic signed [CNT_W-1:0] cnt,
   input  logic                    dec,
   output alu_res_type             res
);
   localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
   localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};

   logic signed [CNT_W-1:0] nxt;

   always_comb begin
      if (dec) begin
         nxt = (cnt == CNT_MIN) ? CNT_MIN : cnt - CNT_W'(1);
      end else begin
         nxt = (cnt == CNT_MAX) ? CNT_MAX : cnt + CNT_W'(1);
      end
      res.cnt     = nxt;
      res.neg     = nxt[CNT_W-1];
      res.le_zero = nxt[CNT_W-1] || (nxt == '0);
   end
endmodule

@@ sim/counting_semaphore_table_core_test.sv @@
// self-checking testbench for the semaphore table core
`timescale 1ns / 1ps
module counting_semaphore_table_core_test;
   import csem_pkg::*;

   localparam int SLOTS = 16;
   localparam int QDEPTH = 16;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [15:0]         new_id;
      logic [PID_W-1:0]    pid;
      logic                last;
   } sem_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_type = REQ_OPEN;
   logic [PID_W-1:0] req_caller_pid = '0;
   logic [15:0] req_sem_id = '0;
   logic signed [CNT_W-1:0] req_init_count = '0;
   logic rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [15:0] rsp_new_id;
   logic [PID_W-1:0] rsp_pid;
   logic rsp_last;

   counting_semaphore_table_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_caller_pid(req_caller_pid),
      .req_sem_id(req_sem_id), .req_init_count(req_init_count),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_new_id(rsp_new_id),
      .rsp_pid(rsp_pid), .rsp_last(rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // shadow of the semaphore table
   bit         sh_valid[SLOTS];
   logic [15:0] sh_id[SLOTS];
   int         sh_count[SLOTS];
   logic [PID_W-1:0] sh_fifo[SLOTS][QDEPTH];
   int         sh_head[SLOTS];
   int         sh_num[SLOTS];
   logic [15:0] sh_next_id = 16'd1;

   sem_result_type expected_results[$];
   int mismatches = 0;

   function automatic void push_result(logic [STATUS_W-1:0] st, logic [15:0] nid,
                                       logic [PID_W-1:0] p, logic l);
      sem_result_type r;
      r.status = st; r.new_id = nid; r.pid = p; r.last = l;
      expected_results.push_back(r);
   endfunction

   function automatic void predict_request(logic [1:0] op, logic [PID_W-1:0] caller,
                                           logic [15:0] id, logic signed [15:0] init);
      int s;
      int c;
      logic [PID_W-1:0] p;
      s = -1;
      if (op == REQ_OPEN) begin
         for (int i = SLOTS - 1; i >= 0; i--) if (!sh_valid[i]) s = i;
         if (s < 0) begin
            push_result(STAT_NOMEM, 16'd0, caller, 1'b1);
            return;
         end
         sh_valid[s] = 1; sh_id[s] = sh_next_id; sh_count[s] = init;
         sh_head[s] = 0; sh_num[s] = 0;
         push_result(STAT_OK, sh_next_id, caller, 1'b1);
         sh_next_id = (sh_next_id == 16'hFFFF) ? 16'd1 : sh_next_id + 16'd1;
         return;
      end
      for (int i = SLOTS - 1; i >= 0; i--) if (sh_valid[i] && sh_id[i] == id) s = i;
      if (s < 0) begin
         push_result(STAT_INVALID, 16'd0, caller, 1'b1);
         return;
      end
      case (op)
         REQ_WAIT: begin
            c = (sh_count[s] > -32768) ? sh_count[s] - 1 : -32768;
            if (c < 0) begin
               if (sh_num[s] >= QDEPTH) begin
                  push_result(STAT_NOMEM, 16'd0, caller, 1'b1);
               end else begin
                  sh_fifo[s][(sh_head[s] + sh_num[s]) % QDEPTH] = caller;
                  sh_num[s]++;
                  sh_count[s] = c;
                  push_result(STAT_BLOCKED, 16'd0, caller, 1'b1);
               end
            end else begin
               sh_count[s] = c;
               push_result(STAT_OK, 16'd0, caller, 1'b1);
            end
         end
         REQ_POST: begin
            c = (sh_count[s] < 32767) ? sh_count[s] + 1 : 32767;
            sh_count[s] = c;
            if (c <= 0 && sh_num[s] > 0) begin
               p = sh_fifo[s][sh_head[s]];
               sh_head[s] = (sh_head[s] + 1) % QDEPTH; sh_num[s]--;
               push_result(STAT_WOKEN, 16'd0, p, 1'b0);
            end
            push_result(STAT_OK, 16'd0, caller, 1'b1);
         end
         default: begin
            while (sh_num[s] > 0) begin
               p = sh_fifo[s][sh_head[s]];
               sh_head[s] = (sh_head[s] + 1) % QDEPTH; sh_num[s]--;
               push_result(STAT_CLOSED, 16'd0, p, 1'b0);
            end
            sh_valid[s] = 0;
            push_result(STAT_OK, 16'd0, caller, 1'b1);
         end
      endcase
   endfunction

   // issue one transaction after a random gap, once the block is idle
   task automatic send_request(logic [1:0] op, logic [PID_W-1:0] caller,
                               logic [15:0] id, logic signed [15:0] init);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      repeat (gap) @(negedge clock);
      while (busy) @(negedge clock);
      req_type <= op; req_caller_pid <= caller; req_sem_id <= id;
      req_init_count <= init; start <= 1'b1;
      @(posedge clock);
      predict_request(op, caller, id, init);
      @(negedge clock);
      start <= 1'b0;
   endtask

   always @(posedge clock) begin
      sem_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result status %0d pid %0d",
                                           rsp_status, rsp_pid);
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status || rsp_new_id !== want.new_id ||
                rsp_pid !== want.pid || rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: exp st %0d id %0d pid %0d last %0d, got st %0d id %0d pid %0d last %0d",
                           want.status, want.new_id, want.pid, want.last,
                           rsp_status, rsp_new_id, rsp_pid, rsp_last);
            end
         end
      end
   end

   function automatic logic [15:0] pick_live_id();
      int s;
      s = $urandom_range(0, SLOTS - 1);
      if (sh_valid[s] && $urandom_range(0, 9) != 0) return sh_id[s];
      return $urandom_range(0, 9) < 5 ? 16'($urandom_range(1, 40)) : 16'($urandom);
   endfunction

   task automatic test_directed();
      send_request(REQ_WAIT, 4'd0, 16'd0, 16'sd0);        // id zero never matches
      send_request(REQ_OPEN, 4'd15, 16'hFFFF, 16'sh7FFF);  // id 1, max count
      send_request(REQ_POST, 4'd1, 16'd1, 16'sd0);         // saturates high
      send_request(REQ_OPEN, 4'd2, 16'd0, -16'sd32768);    // id 2, min count
      send_request(REQ_WAIT, 4'd3, 16'd2, 16'sd0);         // saturates low, blocks
      send_request(REQ_POST, 4'd4, 16'd2, 16'sd0);         // wakes pid 3
      send_request(REQ_OPEN, 4'd5, 16'd0, 16'sd0);         // id 3
      for (int i = 0; i < 16; i++) send_request(REQ_WAIT, 4'(i), 16'd3, 16'sd0);
      send_request(REQ_WAIT, 4'd9, 16'd3, 16'sd0);         // queue full
      send_request(REQ_CLOSE, 4'd6, 16'd3, 16'sd0);        // releases all sixteen
      send_request(REQ_POST, 4'd7, 16'd3, 16'sd0);         // closed id now invalid
      send_request(REQ_OPEN, 4'd8, 16'd0, -16'sd1);
      send_request(REQ_POST, 4'd8, 16'd4, 16'sd0);         // empty queue on post
      send_request(REQ_CLOSE, 4'd8, 16'd4, 16'sd0);
      send_request(REQ_CLOSE, 4'd8, 16'd1, 16'sd0);
      send_request(REQ_CLOSE, 4'd8, 16'd2, 16'sd0);
   endtask

   task automatic test_table_full();
      for (int i = 0; i < 17; i++) send_request(REQ_OPEN, 4'(i), 16'($urandom), 16'sd1);
      for (int i = 0; i < SLOTS; i++)
         if (sh_valid[i]) send_request(REQ_CLOSE, 4'(i), sh_id[i], 16'sd0);
   endtask

   task automatic test_random_traffic();
      logic [1:0] op;
      for (int n = 0; n < 146; n++) begin
         op = 2'($urandom_range(0, 3));
         if (op == REQ_OPEN)
            send_request(op, 4'($urandom), 16'($urandom),
                         $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                   : 16'($signed($urandom_range(0, 6)) - 3));
         else
            send_request(op, 4'($urandom), pick_live_id(), 16'($urandom));
      end
   endtask

   initial begin
      int settle;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_full();
      test_random_traffic();
      settle = 0;
      while (expected_results.size() != 0 && settle < 2000) begin
         @(posedge clock);
         settle++;
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("counting_semaphore_table_core: match");
      else
         $display("counting_semaphore_table_core: mismatch");
      $finish;
   end

   initial begin
      #400ms;
      $display("counting_semaphore_table_core: mismatch");
      $finish;
   end
endmodule
